// ===== sv/vws_pkg.sv =====
// Shared constants, types and register codes of the voltage window supervisor.
package vws_pkg;

   localparam int WINDOW      = 8;
   localparam int SAMPLE_BITS = 12;

   localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);

   localparam int RAW_BITS    = 12;
   localparam int FILT_BITS   = 12;
   localparam int THR_BITS    = 12;
   localparam int TIME_BITS   = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [THR_BITS-1:0]  HIGH_THR_RESET  = THR_BITS'(3300);
   localparam logic [THR_BITS-1:0]  LOW_THR_RESET   = THR_BITS'(2700);
   localparam logic [TIME_BITS-1:0] HIGH_HOLD_RESET = TIME_BITS'(1000);
   localparam logic [TIME_BITS-1:0] LOW_HOLD_RESET  = TIME_BITS'(1000);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HIGH_THRESHOLD = 3'd0,
      CSR_LOW_THRESHOLD  = 3'd1,
      CSR_HIGH_HOLD_TIME = 3'd2,
      CSR_LOW_HOLD_TIME  = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_MIDDLE = 2'd0,
      REGION_HIGH   = 2'd1,
      REGION_LOW    = 2'd2
   } region_type;

endpackage

// ===== sv/voltage_window_supervisor_core.sv =====
// An accepted request word goes to the input register, then to the result register.
// Throughput: one word per cycle unless rsp_stall holds it; the ring, running sum and
// hold timers update in the cycle a word moves from input register to result register.
// Reset (synchronous, active high) empties both stages, restores the register
// defaults and clears the seeded flag, so the next word reseeds the ring.
module voltage_window_supervisor_core
   import vws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_BITS-1:0]      req_raw_sample,
   input  logic [TIME_BITS-1:0]     req_timestamp,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FILT_BITS-1:0]     rsp_filtered_value,
   output logic [1:0]               rsp_region,
   output logic                     rsp_high_qualified,
   output logic                     rsp_low_qualified,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [TIME_BITS-1:0]   s1_time_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FILT_BITS-1:0]   rsp_filt_ff;
   region_type             rsp_region_ff, region;
   logic                   rsp_hq_ff, rsp_lq_ff, hq, lq;

   logic [THR_BITS-1:0]    high_thr_ff, low_thr_ff;
   logic [TIME_BITS-1:0]   high_hold_ff, low_hold_ff;

   logic                   high_timing_ff, low_timing_ff;
   logic [TIME_BITS-1:0]   high_start_ff, low_start_ff;
   logic [TIME_BITS-1:0]   high_elapsed, low_elapsed;

   logic                   out_free, fire, accept;
   logic [SAMPLE_BITS-1:0] filtered;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   vws_avg u_avg (
      .clock    (clock),
      .reset    (reset),
      .step     (fire),
      .sample   (s1_sample_ff),
      .filtered (filtered)
   );

   assign high_elapsed = s1_time_ff - high_start_ff;
   assign low_elapsed  = s1_time_ff - low_start_ff;

   always_comb begin
      priority if (FILT_BITS'(filtered) > FILT_BITS'(high_thr_ff)) begin
         region = REGION_HIGH;
      end else if (FILT_BITS'(filtered) <= FILT_BITS'(low_thr_ff)) begin
         region = REGION_LOW;
      end else begin
         region = REGION_MIDDLE;
      end
      // on entry the elapsed time is zero
      hq = (region == REGION_HIGH) &&
           (high_timing_ff ? (high_elapsed >= high_hold_ff) : (high_hold_ff == '0));
      lq = (region == REGION_LOW) &&
           (low_timing_ff ? (low_elapsed >= low_hold_ff) : (low_hold_ff == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         high_timing_ff <= 1'b0;
         low_timing_ff  <= 1'b0;
         high_start_ff  <= '0;
         low_start_ff   <= '0;
         high_thr_ff    <= HIGH_THR_RESET;
         low_thr_ff     <= LOW_THR_RESET;
         high_hold_ff   <= HIGH_HOLD_RESET;
         low_hold_ff    <= LOW_HOLD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            high_timing_ff <= (region == REGION_HIGH);
            low_timing_ff  <= (region == REGION_LOW);
            if ((region == REGION_HIGH) && !high_timing_ff) begin
               high_start_ff <= s1_time_ff;
            end
            if ((region == REGION_LOW) && !low_timing_ff) begin
               low_start_ff <= s1_time_ff;
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_HIGH_THRESHOLD: high_thr_ff  <= csr_data[THR_BITS-1:0];
               CSR_LOW_THRESHOLD:  low_thr_ff   <= csr_data[THR_BITS-1:0];
               CSR_HIGH_HOLD_TIME: high_hold_ff <= csr_data[TIME_BITS-1:0];
               CSR_LOW_HOLD_TIME:  low_hold_ff  <= csr_data[TIME_BITS-1:0];
               default: ;  // drop writes to unmapped indexes
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_raw_sample[SAMPLE_BITS-1:0];
         s1_time_ff   <= req_timestamp;
      end
      if (fire) begin
         rsp_filt_ff   <= FILT_BITS'(filtered);
         rsp_region_ff <= region;
         rsp_hq_ff     <= hq;
         rsp_lq_ff     <= lq;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_filt_ff;
   assign rsp_region         = rsp_region_ff;
   assign rsp_high_qualified = rsp_hq_ff;
   assign rsp_low_qualified  = rsp_lq_ff;

endmodule

// ===== sv/vws_avg.sv =====
// Moving average over a ring of samples with a running sum.
module vws_avg
   import vws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS-1:0] filtered
);

   logic [SAMPLE_BITS-1:0] ring_ff [WINDOW];
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in, quot;
   logic                   seeded_ff;

   always_comb begin
      if (!seeded_ff) begin
         // seed: every slot holds the first sample
         sum_in  = SUM_BITS'(sample) * SUM_BITS'(WINDOW);
         slot_in = slot_ff;
      end else begin
         sum_in  = sum_ff - SUM_BITS'(ring_ff[slot_ff]) + SUM_BITS'(sample);
         slot_in = (slot_ff == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      end
      quot     = sum_in / SUM_BITS'(WINDOW);
      filtered = quot[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         sum_ff    <= '0;
         seeded_ff <= 1'b0;
      end else if (step) begin
         slot_ff   <= slot_in;
         sum_ff    <= sum_in;
         seeded_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (!seeded_ff) begin
            for (int i = 0; i < WINDOW; i++) begin
               ring_ff[i] <= sample;
            end
         end else begin
            ring_ff[slot_ff] <= sample;
         end
      end
   end

endmodule

// ===== sv/vws_checker.sv =====
// Port-level checks of the supervisor core and their binding.
module vws_core_assert
   import vws_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [FILT_BITS-1:0]     rsp_filtered_value,
   input logic [1:0]               rsp_region,
   input logic                     rsp_high_qualified,
   input logic                     rsp_low_qualified
);

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid right after reset");

   // with no response word held the request side never stalls
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while response stage empty");

   a_hq_in_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_high_qualified) |-> (rsp_region == REGION_HIGH))
      else $error("high qualified outside high region");

   a_lq_in_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_low_qualified) |-> (rsp_region == REGION_LOW))
      else $error("low qualified outside low region");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered_value)
                                    && $stable(rsp_region)
                                    && $stable(rsp_high_qualified)
                                    && $stable(rsp_low_qualified)))
      else $error("stalled response word changed");

endmodule

bind voltage_window_supervisor_core vws_core_assert u_vws_core_assert (.*);

// ===== dv/vws_checker.sv =====
// Scoreboard for the voltage window supervisor: shadows the registers, predicts and compares.
module vws_checker
   import vws_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [RAW_BITS-1:0]      req_raw_sample,
   input  logic [TIME_BITS-1:0]     req_timestamp,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [FILT_BITS-1:0]     rsp_filtered_value,
   input  logic [1:0]               rsp_region,
   input  logic                     rsp_high_qualified,
   input  logic                     rsp_low_qualified,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       pending_words,
   output int                       mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [FILT_BITS-1:0] filtered_value;
      region_type           region;
      logic                 high_qualified;
      logic                 low_qualified;
   } supervisor_word_type;

   // register shadows
   logic [THR_BITS-1:0]    high_thr;
   logic [THR_BITS-1:0]    low_thr;
   logic [TIME_BITS-1:0]   high_hold;
   logic [TIME_BITS-1:0]   low_hold;

   // averaging window and hold timers
   logic [SAMPLE_BITS-1:0] sample_ring [WINDOW];
   logic [SLOT_BITS-1:0]   oldest_slot;
   logic [SUM_BITS-1:0]    window_sum;
   logic                   seeded;
   logic                   high_timing;
   logic                   low_timing;
   logic [TIME_BITS-1:0]   high_start;
   logic [TIME_BITS-1:0]   low_start;

   supervisor_word_type    expected_words[$];
   int                     mismatches = 0;

   assign mismatch_count = mismatches;

   function automatic supervisor_word_type average_and_classify(
      input logic [RAW_BITS-1:0]  raw,
      input logic [TIME_BITS-1:0] now
   );
      logic [SAMPLE_BITS-1:0] sample;
      logic [TIME_BITS-1:0]   elapsed;
      supervisor_word_type    w;
      sample = raw[SAMPLE_BITS-1:0];
      w = '0;
      if (!seeded) begin
         // fill the whole window with the first word
         for (int i = 0; i < WINDOW; i++) sample_ring[i] = sample;
         window_sum = SUM_BITS'(WINDOW * sample);
         seeded = 1'b1;
      end else begin
         window_sum = window_sum - sample_ring[oldest_slot] + sample;
         sample_ring[oldest_slot] = sample;
         oldest_slot = (int'(oldest_slot) + 1 >= WINDOW) ? '0 : oldest_slot + 1'b1;
      end
      w.filtered_value = FILT_BITS'(window_sum / WINDOW);

      if (w.filtered_value > high_thr) w.region = REGION_HIGH;
      else if (w.filtered_value <= low_thr) w.region = REGION_LOW;
      else w.region = REGION_MIDDLE;

      case (w.region)
         REGION_HIGH: begin
            low_timing = 1'b0;
            if (!high_timing) begin
               high_timing = 1'b1;
               high_start = now;
            end
            elapsed = now - high_start;
            w.high_qualified = (elapsed >= high_hold);
         end
         REGION_LOW: begin
            high_timing = 1'b0;
            if (!low_timing) begin
               low_timing = 1'b1;
               low_start = now;
            end
            elapsed = now - low_start;
            w.low_qualified = (elapsed >= low_hold);
         end
         default: begin
            high_timing = 1'b0;
            low_timing = 1'b0;
         end
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      supervisor_word_type want;
      if (reset) begin
         high_thr = HIGH_THR_RESET;
         low_thr = LOW_THR_RESET;
         high_hold = HIGH_HOLD_RESET;
         low_hold = LOW_HOLD_RESET;
         for (int i = 0; i < WINDOW; i++) sample_ring[i] = '0;
         oldest_slot = '0;
         window_sum = '0;
         seeded = 1'b0;
         high_timing = 1'b0;
         low_timing = 1'b0;
         high_start = '0;
         low_start = '0;
         expected_words.delete();
      end else begin
         // compare before push: a word accepted now cannot answer at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word filt=%0d region=%0d hq=%b lq=%b",
                           $realtime, rsp_filtered_value, rsp_region,
                           rsp_high_qualified, rsp_low_qualified);
            end else begin
               want = expected_words.pop_front();
               if (rsp_filtered_value !== want.filtered_value
                   || rsp_region !== want.region
                   || rsp_high_qualified !== want.high_qualified
                   || rsp_low_qualified !== want.low_qualified) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result word differs: expected filt=%0d %s hq=%b lq=%b,",
                              $realtime, want.filtered_value, want.region.name(),
                              want.high_qualified, want.low_qualified,
                              " got filt=%0d region=%0d hq=%b lq=%b",
                              rsp_filtered_value, rsp_region,
                              rsp_high_qualified, rsp_low_qualified);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_words.push_back(average_and_classify(req_raw_sample, req_timestamp));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HIGH_THRESHOLD: high_thr = csr_data[THR_BITS-1:0];
               CSR_LOW_THRESHOLD:  low_thr = csr_data[THR_BITS-1:0];
               CSR_HIGH_HOLD_TIME: high_hold = csr_data[TIME_BITS-1:0];
               CSR_LOW_HOLD_TIME:  low_hold = csr_data[TIME_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Top of the supervisor testbench: clock, reset, stimulus, stalls and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vws_pkg::*;

   localparam int RAW_MAX = (1 << RAW_BITS) - 1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [RAW_BITS-1:0]      req_raw_sample = '0;
   logic [TIME_BITS-1:0]     req_timestamp = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [FILT_BITS-1:0]     rsp_filtered_value;
   logic [1:0]               rsp_region;
   logic                     rsp_high_qualified;
   logic                     rsp_low_qualified;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int pending_words;
   int mismatch_count;
   int idle_pct = 0;
   int stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   voltage_window_supervisor_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_region         (rsp_region),
      .rsp_high_qualified (rsp_high_qualified),
      .rsp_low_qualified  (rsp_low_qualified),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   vws_checker scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_region         (rsp_region),
      .rsp_high_qualified (rsp_high_qualified),
      .rsp_low_qualified  (rsp_low_qualified),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .pending_words      (pending_words),
      .mismatch_count     (mismatch_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_sample(input logic [RAW_BITS-1:0] raw,
                              input logic [TIME_BITS-1:0] stamp);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender until every result word is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all indexes; the unused ones get random data that must be dropped
   task automatic program_registers(input logic [THR_BITS-1:0] hthr,
                                    input logic [THR_BITS-1:0] lthr,
                                    input logic [TIME_BITS-1:0] hhold,
                                    input logic [TIME_BITS-1:0] lhold);
      logic [CSR_DATA_BITS-1:0] word;
      for (int idx = 0; idx < 2 ** CSR_IDX_BITS; idx++) begin
         word = $urandom();
         case (idx)
            CSR_HIGH_THRESHOLD: word[THR_BITS-1:0] = hthr;
            CSR_LOW_THRESHOLD:  word[THR_BITS-1:0] = lthr;
            CSR_HIGH_HOLD_TIME: word = hhold;
            CSR_LOW_HOLD_TIME:  word = lhold;
            default: ;
         endcase
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_BITS'(idx);
         csr_data <= word;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [RAW_BITS-1:0] jitter(input int center);
      int v;
      v = center + int'($urandom_range(0, 32)) - 16;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_BITS'(v);
   endfunction

   initial begin
      logic [TIME_BITS-1:0] stamp;
      logic [THR_BITS-1:0]  hthr;
      logic [THR_BITS-1:0]  lthr;
      logic [TIME_BITS-1:0] hhold;
      logic [TIME_BITS-1:0] lhold;
      int                   level;
      int                   burst_left;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default registers: seed high, cross the timestamp wrap, qualify at exactly the hold
      send_sample(RAW_MAX, 32'hFFFF_FF00);
      send_sample(RAW_MAX, 32'hFFFF_FFFF);
      send_sample(RAW_MAX, 32'h0000_02E7);
      send_sample(RAW_MAX, 32'h0000_02E8);
      // walk down through middle into low, then hold low long enough
      stamp = 32'h0000_02E8;
      repeat (8) begin
         stamp += 300;
         send_sample('0, stamp);
      end
      send_sample('0, stamp + 1000);
      drain();

      // inverted thresholds with zero hold: qualify on entry
      program_registers('0, '1, '0, '0);
      repeat (2) send_sample(RAW_MAX, stamp);
      repeat (8) send_sample('0, stamp);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               hthr = '1; lthr = '0; hhold = '0; lhold = '0;
            end
            1: begin
               hthr = '0; lthr = '1; hhold = '1; lhold = '1;
            end
            default: begin
               lthr = THR_BITS'($urandom_range(100, 2500));
               hthr = THR_BITS'(lthr + $urandom_range(50, 1400));
               hhold = $urandom_range(0, 300);
               lhold = $urandom_range(0, 300);
               if ($urandom_range(0, 3) == 0) {hthr, lthr} = {lthr, hthr};
               if ($urandom_range(0, 3) == 0) hhold = $urandom();
            end
         endcase
         program_registers(hthr, lthr, hhold, lhold);

         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase

         stamp = $urandom();
         burst_left = 0;
         for (int n = 0; n < 235; n++) begin
            // dwell near one level so the average settles and the timers run
            if (burst_left == 0) begin
               case ($urandom_range(0, 5))
                  0: level = int'(hthr) + int'($urandom_range(0, 40));
                  1: level = int'(lthr) - int'($urandom_range(0, 40));
                  2: level = (int'(hthr) + int'(lthr)) / 2;
                  3: level = 0;
                  4: level = RAW_MAX;
                  default: level = $urandom_range(0, RAW_MAX);
               endcase
               burst_left = $urandom_range(4, 40);
            end
            burst_left--;
            if ($urandom_range(0, 9) == 0) begin
               send_sample(RAW_BITS'($urandom()), $urandom());
            end else begin
               stamp += $urandom_range(0, 24);
               send_sample(jitter(level), stamp);
            end
            if (n == 117 && phase % 2 == 0) drain();
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
